// ===== hdl/b2da_pkg.sv =====
package b2da_pkg;

    localparam int VALUE_WIDTH_DEF  = 32;
    localparam int IN_WIDTH         = 32;
    localparam int DIGIT_CHAR_WIDTH = 6;
    localparam int OUT_TDATA_WIDTH  = 8;
    localparam logic [DIGIT_CHAR_WIDTH-1:0] ASCII_ZERO = 6'h30;
    localparam logic [3:0] DEC_MAX_DIGIT = 4'd9;
    localparam logic [3:0] DABBLE_LIMIT  = 4'd5;
    localparam logic [3:0] DABBLE_ADJ    = 4'd3;

    typedef struct packed {
        logic load;
        logic shift_conv;
        logic shift_skip;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic conv_last;
        logic top_zero;
        logic last_digit;
        logic out_free;
    } t_status;

endpackage

// ===== hdl/binary_to_decimal_ascii_unit.sv =====
// Binary to decimal ASCII digit serializer, most significant digit first.
// Sequence: an accept step, then VALUE_WIDTH (capped at 32) double-dabble shift steps,
// then one skip step per skipped leading zero, one to leave the skip phase, one per digit.
// One item at a time: a new value is accepted only after the previous value's last digit
// has been emitted; digits leave one per cycle while the output is not stalled.
// Reset (synchronous, active low) returns the controller to idle and empties the output.
module binary_to_decimal_ascii_unit #(
    parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [b2da_pkg::IN_WIDTH-1:0]        s_axis_tdata,  // [31:0] value
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [b2da_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata,  // [5:0] digit_char, [7:6] zero
    output logic                                 m_axis_tlast
);
    import b2da_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic [DIGIT_CHAR_WIDTH-1:0] digit_char;

    b2da_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    b2da_dpath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_value       (s_axis_tdata),
        .i_cmd         (cmd),
        .o_status      (status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .o_digit_char  (digit_char),
        .m_axis_tlast  (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_TDATA_WIDTH-DIGIT_CHAR_WIDTH){1'b0}}, digit_char};

endmodule

// ===== hdl/b2da_ctrl.sv =====
module b2da_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  b2da_pkg::t_status i_status,
    output b2da_pkg::t_cmd    o_cmd
);
    import b2da_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SKIP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign s_axis_tready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.shift_conv = 1'b1;
                if (i_status.conv_last) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (i_status.top_zero && !i_status.last_digit) begin
                    o_cmd.shift_skip = 1'b1;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.last_digit) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_emit_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && i_status.last_digit) |=> (r_state == ST_IDLE))
        else $error("controller not idle after final digit");

    a_conv_to_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.shift_conv && i_status.conv_last) |=> (r_state == ST_SKIP))
        else $error("conversion end not followed by skip phase");

    a_idle_no_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !(o_cmd.shift_conv || o_cmd.shift_skip || o_cmd.emit))
        else $error("datapath command issued while idle");

endmodule

// ===== hdl/b2da_dpath.sv =====
module b2da_dpath #(
    parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [b2da_pkg::IN_WIDTH-1:0]        i_value,
    input  b2da_pkg::t_cmd                       i_cmd,
    output b2da_pkg::t_status                    o_status,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [b2da_pkg::DIGIT_CHAR_WIDTH-1:0] o_digit_char,
    output logic                                 m_axis_tlast
);
    import b2da_pkg::*;

    localparam int EW     = (VALUE_WIDTH < IN_WIDTH) ? VALUE_WIDTH : IN_WIDTH;
    localparam int NDIG   = (EW * 3) / 10 + 1;
    localparam int BCD_W  = NDIG * 4;
    localparam int CNT_W  = $clog2(EW + 1);
    localparam int LEFT_W = $clog2(NDIG + 1);

    logic [EW-1:0]     r_bin;
    logic [BCD_W-1:0]  r_bcd;
    logic [BCD_W-1:0]  bcd_adj;
    logic [CNT_W-1:0]  r_cnt;
    logic [LEFT_W-1:0] r_left;
    logic              r_out_valid;
    logic [DIGIT_CHAR_WIDTH-1:0] r_out_char;
    logic              r_out_last;
    logic [3:0]        top_digit;

    assign top_digit = r_bcd[BCD_W-1 -: 4];

    always_comb begin
        logic [3:0] d;
        for (int k = 0; k < NDIG; k++) begin
            d = r_bcd[k*4 +: 4];
            bcd_adj[k*4 +: 4] = (d >= DABBLE_LIMIT) ? d + DABBLE_ADJ : d;
        end
    end

    assign o_status.conv_last  = (r_cnt == CNT_W'(1));
    assign o_status.top_zero   = (top_digit == 4'd0);
    assign o_status.last_digit = (r_left == LEFT_W'(1));
    assign o_status.out_free   = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin  <= i_value[EW-1:0];
            r_bcd  <= '0;
            r_cnt  <= CNT_W'(EW);
            r_left <= LEFT_W'(NDIG);
        end else if (i_cmd.shift_conv) begin
            r_bcd <= {bcd_adj[BCD_W-2:0], r_bin[EW-1]};
            r_bin <= {r_bin[EW-2:0], 1'b0};
            r_cnt <= r_cnt - CNT_W'(1);
        end else if (i_cmd.shift_skip || i_cmd.emit) begin
            r_bcd  <= {r_bcd[BCD_W-5:0], 4'd0};
            r_left <= r_left - LEFT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_char <= ASCII_ZERO + {{(DIGIT_CHAR_WIDTH-4){1'b0}}, top_digit};
            r_out_last <= o_status.last_digit;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign o_digit_char  = r_out_char;
    assign m_axis_tlast  = r_out_last;

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (top_digit <= DEC_MAX_DIGIT))
        else $error("emitted BCD digit out of range");

    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit || i_cmd.shift_skip) |-> (r_left != '0))
        else $error("digit counter underflow");

    a_emit_holds_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || m_axis_tready))
        else $error("output register overwritten before transaction");

endmodule

// ===== tb/digit_stream_checker.sv =====
module digit_stream_checker #(
    parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    input  logic                                 i_s_tready,
    input  logic [b2da_pkg::IN_WIDTH-1:0]        i_s_tdata,   // [31:0] value
    input  logic                                 i_m_tvalid,
    input  logic                                 i_m_tready,
    input  logic [b2da_pkg::OUT_TDATA_WIDTH-1:0] i_m_tdata,   // [5:0] digit_char, [7:6] zero
    input  logic                                 i_m_tlast,
    output int                                   o_fail_count,
    output int                                   o_pending
);

    import b2da_pkg::*;

    localparam logic [63:0] DEC_BASE = 64'd10;
    localparam logic [63:0] VALUE_MASK =
        (VALUE_WIDTH >= 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 64'd1);

    typedef struct packed {
        logic [DIGIT_CHAR_WIDTH-1:0] digit_char;
        logic                        last;
    } t_digit;

    t_digit expected_digits[$];
    int     fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_digits.size();

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        fail_count++;
    endtask

    // decimal digits of one value, most significant first
    task automatic queue_decimal_digits(input logic [IN_WIDTH-1:0] value);
        logic [63:0] rem;
        logic [3:0]  digs[20];
        int          n;
        int          k;
        t_digit      d;
        rem = {{(64-IN_WIDTH){1'b0}}, value} & VALUE_MASK;
        n   = 0;
        do begin
            digs[n] = 4'(rem % DEC_BASE);
            rem     = rem / DEC_BASE;
            n++;
        end while (rem != 0 && n < 20);
        for (k = n - 1; k >= 0; k--) begin
            d.digit_char = ASCII_ZERO + DIGIT_CHAR_WIDTH'(digs[k]);
            d.last       = (k == 0);
            expected_digits.push_back(d);
        end
    endtask

    always @(posedge i_clk) begin
        t_digit exp_d;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                queue_decimal_digits(i_s_tdata);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_digits.size() == 0) begin
                    report_mismatch($sformatf("unexpected digit tdata=%h tlast=%b",
                                              i_m_tdata, i_m_tlast));
                end else begin
                    exp_d = expected_digits.pop_front();
                    if (i_m_tdata[DIGIT_CHAR_WIDTH-1:0] !== exp_d.digit_char) begin
                        report_mismatch($sformatf("digit_char got %h expected %h",
                                                  i_m_tdata[DIGIT_CHAR_WIDTH-1:0],
                                                  exp_d.digit_char));
                    end
                    if (i_m_tlast !== exp_d.last) begin
                        report_mismatch($sformatf("tlast got %b expected %b",
                                                  i_m_tlast, exp_d.last));
                    end
                    if (i_m_tdata[OUT_TDATA_WIDTH-1:DIGIT_CHAR_WIDTH] !== '0) begin
                        report_mismatch($sformatf("tdata padding got %b",
                                        i_m_tdata[OUT_TDATA_WIDTH-1:DIGIT_CHAR_WIDTH]));
                    end
                end
            end
        end
    end

endmodule

// ===== tb/testbench.sv =====
module testbench;

    import b2da_pkg::*;

    localparam int RANDOM_PER_PHASE = 53;
    localparam int HOLD_CYCLES      = 400;
    localparam int STALL_LIMIT      = 3000;
    localparam int DRAIN_CYCLES     = 60;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [IN_WIDTH-1:0]        s_axis_tdata;   // [31:0] value
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata;   // [5:0] digit_char, [7:6] zero
    logic                       m_axis_tlast;

    int   fail_count;
    int   pending;
    int   send_idle_pct = 14;
    int   recv_idle_pct = 69;
    logic hold_req      = 1'b0;
    logic hold_done     = 1'b0;
    int   stall_cycles  = 0;

    binary_to_decimal_ascii_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    digit_stream_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tlast    (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // receiver: random backpressure, plus one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end
            m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_value(input logic [IN_WIDTH-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = value;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    function automatic logic [IN_WIDTH-1:0] random_value();
        logic [63:0] lo;
        logic [63:0] hi;
        int          ndig;
        int          k;
        case ($urandom_range(3))
            0: random_value = $urandom;
            1: random_value = $urandom_range(99);
            default: begin
                // uniform digit count, then a value with that many digits
                ndig = $urandom_range(10, 1);
                lo   = 64'd1;
                for (k = 1; k < ndig; k++) lo = lo * 64'd10;
                hi = lo * 64'd10 - 64'd1;
                if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
                random_value = $urandom_range(hi[31:0], lo[31:0]);
            end
        endcase
    endfunction

    logic [IN_WIDTH-1:0] directed_values[] = '{
        32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000,
        32'd65535, 32'd65536, 32'd99999999, 32'd100000000, 32'd999999999,
        32'd1000000000, 32'd4294967294, 32'hFFFF_FFFF, 32'h8000_0000,
        32'hAAAA_AAAA, 32'h5555_5555, 32'd1234567890, 32'd10101, 32'd7
    };

    initial begin
        int phase;
        int n;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_rst_n       = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (n = 0; n < directed_values.size(); n++) send_value(directed_values[n]);

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 14; recv_idle_pct = 69; end
                1: begin send_idle_pct = 69; recv_idle_pct = 14; end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_req      = 1'b1;
                end
            endcase
            for (n = 0; n < RANDOM_PER_PHASE; n++) send_value(random_value());
        end

        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
